// ===== rtl/fsdc_pkg.sv =====
// Shared types, codes and defaults for the FAT sector dirty cache.
package fsdc_pkg;

  // Default sizes.
  localparam int SLOTS_DEF              = 32;
  localparam int MBR_SECTORS_DEF        = 63;
  localparam int FAT_REGION_SECTORS_DEF = 4;
  localparam int DIR_SECTORS_DEF        = 32;

  // Access modes.
  localparam logic [1:0] MODE_READ    = 2'd0;
  localparam logic [1:0] MODE_WRITE   = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;
  localparam logic [1:0] MODE_ACK     = 2'd3;

  // Region codes.
  localparam logic [2:0] REG_MBR      = 3'd0;
  localparam logic [2:0] REG_RESERVED = 3'd1;
  localparam logic [2:0] REG_BOOT     = 3'd2;
  localparam logic [2:0] REG_FAT      = 3'd3;
  localparam logic [2:0] REG_ROOT     = 3'd4;
  localparam logic [2:0] REG_DATA     = 3'd5;

  // Decoded view of one access.
  typedef struct packed {
    logic [2:0]  region;
    logic [4:0]  rsec;
    logic [15:0] clus;
    logic        lookup;    // tag store must be scanned
    logic        fat_wr;    // write to a FAT sector
    logic        root_wr;   // write to a root directory sector
    logic        root_last; // that sector is the last of the root directory
    logic        data_wr;   // write to a data cluster
  } decode_t;

endpackage

// ===== rtl/fsdc_decode.sv =====
// Sector address decoder: region, sector within region, cluster number.
module fsdc_decode import fsdc_pkg::*; #(
  parameter int MBR_SECTORS        = MBR_SECTORS_DEF,
  parameter int FAT_REGION_SECTORS = FAT_REGION_SECTORS_DEF,
  parameter int DIR_SECTORS        = DIR_SECTORS_DEF
) (
  input  logic [1:0]  mode,
  input  logic [15:0] lba,
  output decode_t     dec
);

  localparam int DIR_FIRST  = 1 + FAT_REGION_SECTORS;
  localparam int DATA_FIRST = DIR_FIRST + DIR_SECTORS;

  logic [15:0] ps;
  logic        is_wr;

  assign ps    = lba - 16'(MBR_SECTORS);
  assign is_wr = (mode == MODE_WRITE);

  // Walk the regions in address order.
  always_comb begin
    dec = '0;
    if (mode == MODE_RELEASE) begin
      dec.region = REG_DATA;
      dec.clus   = lba;
      dec.lookup = (lba != 16'd0);
    end else if (lba == 16'd0) begin
      dec.region = REG_MBR;
    end else if ({1'b0, lba} < 17'(MBR_SECTORS)) begin
      dec.region = REG_RESERVED;
    end else if (ps == 16'd0) begin
      dec.region = REG_BOOT;
    end else if (ps < 16'(DIR_FIRST)) begin
      dec.region = REG_FAT;
      dec.rsec   = 5'(ps - 16'd1);
      dec.fat_wr = is_wr;
    end else if (ps < 16'(DATA_FIRST)) begin
      dec.region    = REG_ROOT;
      dec.rsec      = 5'(ps - 16'(DIR_FIRST));
      dec.root_wr   = is_wr;
      dec.root_last = (ps == 16'(DATA_FIRST - 1));
    end else begin
      dec.region  = REG_DATA;
      dec.clus    = ps - 16'(DATA_FIRST) + 16'd2;
      dec.lookup  = (mode == MODE_READ) || is_wr;
      dec.data_wr = is_wr;
    end
  end

endmodule

// ===== rtl/fsdc_tag_ram.sv =====
// Dirty cluster tag memory with per-slot valid bits; a free slot reads as zero.
module fsdc_tag_ram import fsdc_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF,
  localparam int SW   = $clog2(SLOTS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [SW-1:0] rd_addr,
  output logic [15:0]   rd_data,
  input  logic          wr_en,
  input  logic          rel_en,
  input  logic [SW-1:0] wr_addr,
  input  logic [15:0]   wr_data
);

  logic [15:0]      mem [SLOTS];
  logic [SLOTS-1:0] valid;
  logic [15:0]      rd_q;
  logic             rd_vld;

  // Write the tag array and read one entry a cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Track which slots hold a tag; reset frees every slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end else if (rel_en) begin
        valid[wr_addr] <= 1'b0;
      end
      if (rd_en) begin
        rd_vld <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_q : 16'd0;

  // Update and release never coincide, and never overlap a read.
  a_one_update: assert property (@(posedge clk) disable iff (rst) !(wr_en && rel_en))
    else $error("tag write and release in the same cycle");
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(rd_en && (wr_en || rel_en)))
    else $error("tag read overlaps an update");

endmodule

// ===== rtl/fat_sector_dirty_cache.sv =====
// Top level: access sequencer, flags and result register of the dirty cache.
//
// One access (mode, lba) is taken when start is high and busy is low. Accesses
// that look up the tag store (data reads, data writes, releases of a nonzero
// cluster) scan every slot of the tag memory, one read a cycle through its
// single port, then drain the last read and commit; every other access goes
// straight from acceptance to the commit state. The result appears for a
// single cycle with done high and must be captured then: there is no way to
// hold it. Start may be raised again in the cycle done is shown.
module fat_sector_dirty_cache import fsdc_pkg::*; #(
  parameter int SLOTS              = SLOTS_DEF,
  parameter int MBR_SECTORS        = MBR_SECTORS_DEF,
  parameter int FAT_REGION_SECTORS = FAT_REGION_SECTORS_DEF,
  parameter int DIR_SECTORS        = DIR_SECTORS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode,
  input  logic [15:0] lba,
  output logic        done,
  output logic [2:0]  region,
  output logic [4:0]  region_sector,
  output logic [15:0] cluster,
  output logic [4:0]  slot,
  output logic        slot_hit,
  output logic        slot_new,
  output logic        evicted,
  output logic [15:0] evicted_cluster,
  output logic        sync_pending,
  output logic        dir_pending
);

  localparam int SW = $clog2(SLOTS);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]    state;
  logic          accept;
  decode_t       dec;
  decode_t       dec_q;
  logic [1:0]    mode_q;
  logic [SW-1:0] rd_addr;
  logic          cmp_en;
  logic [SW-1:0] cmp_idx;
  logic [15:0]   tag;
  logic          hit_found;
  logic [SW-1:0] hit_idx;
  logic          free_found;
  logic [SW-1:0] free_idx;
  logic [15:0]   slot0_tag;
  logic          sync_flag;
  logic          dir_flag;

  logic          rd_en;
  logic          wr_en;
  logic          rel_en;
  logic [SW-1:0] wr_addr;
  logic          take_new;
  logic          take_evict;
  logic          sync_next;
  logic          dir_next;
  logic [SW-1:0] slot_next;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign rd_en  = (state == S_SCAN);

  fsdc_decode #(
    .MBR_SECTORS        (MBR_SECTORS),
    .FAT_REGION_SECTORS (FAT_REGION_SECTORS),
    .DIR_SECTORS        (DIR_SECTORS)
  ) u_decode (
    .mode (mode),
    .lba  (lba),
    .dec  (dec)
  );

  fsdc_tag_ram #(
    .SLOTS (SLOTS)
  ) u_tag_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (tag),
    .wr_en   (wr_en),
    .rel_en  (rel_en),
    .wr_addr (wr_addr),
    .wr_data (dec_q.clus)
  );

  // Sequence: accept, for a lookup scan all slots and drain the last read, commit.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_addr <= '0;
      cmp_en  <= 1'b0;
    end else begin
      cmp_en <= (state == S_SCAN);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rd_addr <= '0;
            state   <= dec.lookup ? S_SCAN : S_DONE;
          end
        end
        S_SCAN: begin
          cmp_idx <= rd_addr;
          if (rd_addr == SW'(SLOTS - 1)) begin
            state <= S_DRAIN;
          end else begin
            rd_addr <= rd_addr + SW'(1);
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Latch the access and collect the lowest match, the lowest free slot
  // and the tag of slot zero as the reads come back.
  always_ff @(posedge clk) begin
    if (accept) begin
      dec_q      <= dec;
      mode_q     <= mode;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      hit_idx    <= '0;
      free_idx   <= '0;
      slot0_tag  <= '0;
    end else if (cmp_en) begin
      if (tag == dec_q.clus && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= cmp_idx;
      end
      if (tag == 16'd0 && !free_found) begin
        free_found <= 1'b1;
        free_idx   <= cmp_idx;
      end
      if (cmp_idx == '0) begin
        slot0_tag <= tag;
      end
    end
  end

  // Decide the tag update and the next flag values.
  always_comb begin
    take_new   = dec_q.data_wr && !hit_found && free_found;
    take_evict = dec_q.data_wr && !hit_found && !free_found;
    wr_en      = (state == S_DONE) && (take_new || take_evict);
    rel_en     = (state == S_DONE) && (mode_q == MODE_RELEASE) && hit_found;
    wr_addr    = '0;
    slot_next  = '0;
    if (hit_found) begin
      wr_addr   = hit_idx;
      slot_next = hit_idx;
    end else if (take_new) begin
      wr_addr   = free_idx;
      slot_next = free_idx;
    end

    sync_next = sync_flag;
    dir_next  = dir_flag;
    if ((dec_q.fat_wr || dec_q.data_wr) && dir_flag) begin
      sync_next = 1'b1;
      dir_next  = 1'b0;
    end
    if (dec_q.root_wr) begin
      if (dec_q.root_last) begin
        sync_next = 1'b1;
        dir_next  = 1'b0;
      end else begin
        dir_next = 1'b1;
      end
    end
    if (take_evict) begin
      sync_next = 1'b1;
    end
    if (mode_q == MODE_ACK) begin
      sync_next = 1'b0;
    end
  end

  // Commit flags and raise done for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_flag <= 1'b0;
      dir_flag  <= 1'b0;
      done      <= 1'b0;
    end else begin
      done <= (state == S_DONE);
      if (state == S_DONE) begin
        sync_flag <= sync_next;
        dir_flag  <= dir_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      region          <= dec_q.region;
      region_sector   <= dec_q.rsec;
      cluster         <= dec_q.clus;
      slot            <= 5'(slot_next);
      slot_hit        <= hit_found;
      slot_new        <= take_new;
      evicted         <= take_evict;
      evicted_cluster <= take_evict ? slot0_tag : 16'd0;
      sync_pending    <= sync_next;
      dir_pending     <= dir_next;
    end
  end

  // A result word lasts one cycle and leaves the block ready.
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held longer than one cycle");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while still busy");
  a_evict_sync: assert property (@(posedge clk) disable iff (rst)
    done && evicted |-> sync_pending)
    else $error("eviction without sync");
  a_outcome_excl: assert property (@(posedge clk) disable iff (rst)
    done |-> $onehot0({slot_hit, slot_new, evicted}))
    else $error("more than one lookup outcome");

endmodule

// ===== tb/fat_sector_dirty_cache_tb.sv =====
// Self-checking testbench for the FAT sector dirty cache: directed and random accesses.
`timescale 1ns / 1ps

module fat_sector_dirty_cache_tb;
  import fsdc_pkg::*;

  localparam int DIR_FIRST   = 1 + FAT_REGION_SECTORS_DEF;
  localparam int DATA_FIRST  = DIR_FIRST + DIR_SECTORS_DEF;
  localparam int DATA_LBA0   = MBR_SECTORS_DEF + DATA_FIRST - 2;  // lba of cluster 0
  localparam int MAX_CLUSTER = 65535 - DATA_LBA0;
  localparam int HOT_COUNT   = 44;
  localparam int RANDOM_WORDS = 800;
  localparam int IDLE_LIMIT  = 2000;
  localparam int SETTLE_CYCLES = 40;

  // One result word as seen on the result ports.
  typedef struct packed {
    logic [2:0]  region;
    logic [4:0]  rsec;
    logic [15:0] clus;
    logic [4:0]  slot;
    logic        hit;
    logic        fresh;
    logic        ev;
    logic [15:0] ev_clus;
    logic        sync;
    logic        dirp;
  } access_result_t;

  // Tag store and flag predictor plus the queue of results still owed.
  class dirty_cache_model;
    logic [15:0]    tags [SLOTS_DEF];
    bit             sync_f;
    bit             dir_f;
    access_result_t owed_results [$];
    int             errors;

    function new();
      foreach (tags[i]) tags[i] = '0;
      sync_f = 0;
      dir_f  = 0;
      errors = 0;
    endfunction

    // Return the lowest slot holding tag, or -1.
    function int lowest_slot(logic [15:0] tag);
      int k;
      k = -1;
      for (int i = 0; i < SLOTS_DEF; i++)
        if (k < 0 && tags[i] == tag) k = i;
      return k;
    endfunction

    // Predict the result of one accepted access and advance the state.
    function void take_access(logic [1:0] md, logic [15:0] addr);
      access_result_t r;
      int k;
      int ps;
      r = '0;
      if (md == MODE_RELEASE) begin
        r.region = REG_DATA;
        r.clus = addr;
        if (addr != 0) begin
          k = lowest_slot(addr);
          if (k >= 0) begin
            r.slot = k[4:0];
            r.hit = 1'b1;
            tags[k] = '0;
          end
        end
      end else if (addr == 0) begin
        r.region = REG_MBR;
      end else if (addr < MBR_SECTORS_DEF) begin
        r.region = REG_RESERVED;
      end else begin
        ps = int'(addr) - MBR_SECTORS_DEF;
        if (ps == 0) begin
          r.region = REG_BOOT;
        end else if (ps < DIR_FIRST) begin
          r.region = REG_FAT;
          r.rsec = 5'(ps - 1);
          if (md == MODE_WRITE && dir_f) begin
            sync_f = 1;
            dir_f = 0;
          end
        end else if (ps < DATA_FIRST) begin
          r.region = REG_ROOT;
          r.rsec = 5'(ps - DIR_FIRST);
          if (md == MODE_WRITE) begin
            dir_f = 1;
            // last root sector turns the pending directory write into a sync
            if (ps == DATA_FIRST - 1) begin
              sync_f = 1;
              dir_f = 0;
            end
          end
        end else begin
          r.region = REG_DATA;
          r.clus = 16'(ps - DATA_FIRST + 2);
          if (md == MODE_READ) begin
            k = lowest_slot(r.clus);
            if (k >= 0) begin
              r.slot = k[4:0];
              r.hit = 1'b1;
            end
          end else if (md == MODE_WRITE) begin
            if (dir_f) begin
              sync_f = 1;
              dir_f = 0;
            end
            k = lowest_slot(r.clus);
            if (k >= 0) begin
              r.slot = k[4:0];
              r.hit = 1'b1;
            end else begin
              k = lowest_slot('0);
              if (k >= 0) begin
                r.slot = k[4:0];
                r.fresh = 1'b1;
                tags[k] = r.clus;
              end else begin
                // store full: evict slot 0 for write-back
                r.ev = 1'b1;
                r.ev_clus = tags[0];
                tags[0] = r.clus;
                sync_f = 1;
              end
            end
          end
        end
      end
      if (md == MODE_ACK) sync_f = 0;
      r.sync = sync_f;
      r.dirp = dir_f;
      owed_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] exp, logic [15:0] act);
      if (act !== exp) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp, act);
      end
    endfunction

    // Check one result word against the oldest prediction.
    function void check_result(access_result_t got);
      access_result_t exp;
      if (owed_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual %p", $time, got);
        return;
      end
      exp = owed_results.pop_front();
      compare_field("region", 16'(exp.region), 16'(got.region));
      compare_field("region_sector", 16'(exp.rsec), 16'(got.rsec));
      compare_field("cluster", exp.clus, got.clus);
      compare_field("slot", 16'(exp.slot), 16'(got.slot));
      compare_field("slot_hit", 16'(exp.hit), 16'(got.hit));
      compare_field("slot_new", 16'(exp.fresh), 16'(got.fresh));
      compare_field("evicted", 16'(exp.ev), 16'(got.ev));
      compare_field("evicted_cluster", exp.ev_clus, got.ev_clus);
      compare_field("sync_pending", 16'(exp.sync), 16'(got.sync));
      compare_field("dir_pending", 16'(exp.dirp), 16'(got.dirp));
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [1:0]  mode = MODE_READ;
  logic [15:0] lba = '0;
  logic        busy;
  logic        done;
  logic [2:0]  region;
  logic [4:0]  region_sector;
  logic [15:0] cluster;
  logic [4:0]  slot;
  logic        slot_hit;
  logic        slot_new;
  logic        evicted;
  logic [15:0] evicted_cluster;
  logic        sync_pending;
  logic        dir_pending;

  dirty_cache_model model = new();
  logic [15:0] hot_clusters [HOT_COUNT];
  int idle_cycles = 0;

  fat_sector_dirty_cache DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .lba(lba),
    .done(done),
    .region(region),
    .region_sector(region_sector),
    .cluster(cluster),
    .slot(slot),
    .slot_hit(slot_hit),
    .slot_new(slot_new),
    .evicted(evicted),
    .evicted_cluster(evicted_cluster),
    .sync_pending(sync_pending),
    .dir_pending(dir_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check each result word and count cycles with no handshake.
  always @(posedge clk) begin
    if (!rst) begin
      if (done)
        model.check_result({region, region_sector, cluster, slot, slot_hit, slot_new,
                            evicted, evicted_cluster, sync_pending, dir_pending});
      if ((start && !busy) || done)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Stop a hung run.
  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Present one access word and hold it until the block takes it.
  task automatic send_access(logic [1:0] md, logic [15:0] addr);
    start <= 1'b1;
    mode <= md;
    lba <= addr;
    do @(posedge clk); while (busy !== 1'b0);
    model.take_access(md, addr);
  endtask

  // Drop start and put junk on the payload while idling.
  task automatic idle_for(int n);
    if (n > 0) begin
      start <= 1'b0;
      mode <= 2'($urandom_range(0, 3));
      lba <= 16'($urandom);
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold off until every owed result has come back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (model.owed_results.size() != 0) @(posedge clk);
  endtask

  // Mostly data traffic on a small cluster set so the store fills and evicts.
  task automatic send_random_access();
    int r;
    logic [15:0] c;
    r = $urandom_range(0, 99);
    c = hot_clusters[$urandom_range(0, HOT_COUNT - 1)];
    if (r < 40)
      send_access(MODE_WRITE, 16'(c + DATA_LBA0));
    else if (r < 60)
      send_access(MODE_READ, 16'(c + DATA_LBA0));
    else if (r < 72)
      send_access(MODE_RELEASE, c);
    else if (r < 77)
      send_access(MODE_ACK, 16'($urandom));
    else if (r < 85)
      send_access(MODE_WRITE, 16'($urandom_range(MBR_SECTORS_DEF + 1,
                                                 MBR_SECTORS_DEF + DATA_FIRST - 1)));
    else
      send_access(2'($urandom_range(0, 3)), 16'($urandom));
  endtask

  initial begin
    logic [1:0]  dir_modes [23];
    logic [15:0] dir_lbas [23];
    int i;

    // decode edges, flag sequences, hit/miss/release corners
    dir_modes = '{MODE_READ, MODE_WRITE, MODE_READ, MODE_WRITE, MODE_WRITE, MODE_READ,
                  MODE_WRITE, MODE_WRITE, MODE_ACK, MODE_WRITE, MODE_WRITE, MODE_ACK,
                  MODE_WRITE, MODE_WRITE, MODE_WRITE, MODE_READ, MODE_READ, MODE_WRITE,
                  MODE_RELEASE, MODE_RELEASE, MODE_RELEASE, MODE_WRITE, MODE_ACK};
    dir_lbas = '{16'd0, 16'd0, 16'd1, 16'(MBR_SECTORS_DEF - 1), 16'(MBR_SECTORS_DEF),
                 16'(MBR_SECTORS_DEF + 1), 16'(MBR_SECTORS_DEF + DIR_FIRST),
                 16'(MBR_SECTORS_DEF + 1), 16'(MBR_SECTORS_DEF + DIR_FIRST - 1),
                 16'(MBR_SECTORS_DEF + DATA_FIRST - 2),
                 16'(MBR_SECTORS_DEF + DATA_FIRST - 1), 16'hFFFF,
                 16'(MBR_SECTORS_DEF + DIR_FIRST), 16'(DATA_LBA0 + 2), 16'hFFFF,
                 16'hFFFF, 16'(DATA_LBA0 + 3), 16'(DATA_LBA0 + 2), 16'd2, 16'd0,
                 16'hFFFF, 16'(DATA_LBA0 + 3), 16'(DATA_LBA0 + 2)};

    foreach (hot_clusters[k]) hot_clusters[k] = 16'($urandom_range(2, MAX_CLUSTER));
    hot_clusters[0] = 16'd2;
    hot_clusters[1] = 16'(MAX_CLUSTER);

    // hold reset before the first access
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < 23; i++) begin
      send_access(dir_modes[i], dir_lbas[i]);
      idle_for(pick_gap());
    end
    drain();

    // the third block of words runs with no gaps at all
    for (i = 0; i < RANDOM_WORDS; i++) begin
      send_random_access();
      if (i % 200 == 199)
        drain();
      else if (i / 200 != 2)
        idle_for(pick_gap());
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (model.owed_results.size() != 0) begin
      model.errors++;
      $display("%0t: %0d results never arrived, expected %p", $time,
               model.owed_results.size(), model.owed_results[0]);
    end
    if (model.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/fsdc_pkg.sv
rtl/fsdc_decode.sv
rtl/fsdc_tag_ram.sv
rtl/fat_sector_dirty_cache.sv
tb/fat_sector_dirty_cache_tb.sv
